// File: design/cfp_pkg.sv
// command frame parser package: slot geometry, register map, ascii codes
// and the frame snapshot type shared by the front, queue and back modules
package cfp_pkg;

  localparam int FrameSlots    = 8;
  localparam int DirectionSlot = 1;
  localparam int VelocitySlot  = 2;
  localparam int QueueDepth    = 2;

  localparam int VelDigits = 3;
  localparam int AddrW     = 3;
  localparam int DataW     = 32;

  localparam logic RegStart = 1'b0;
  localparam logic RegStop  = 1'b1;

  localparam logic [7:0] StartReset = 8'd2;
  localparam logic [7:0] StopReset  = 8'd3;

  localparam logic [7:0] AsciiZero = 8'd48;
  localparam logic [7:0] AsciiNine = 8'd57;
  localparam logic [7:0] AsciiH    = 8'h48;
  localparam logic [7:0] AsciiF    = 8'h46;
  localparam logic [7:0] AsciiB    = 8'h42;
  localparam logic [7:0] AsciiL    = 8'h4c;
  localparam logic [7:0] AsciiR    = 8'h52;

  typedef enum logic [2:0] {
    DirStop  = 3'd0,
    DirFwd   = 3'd1,
    DirBack  = 3'd2,
    DirLeft  = 3'd3,
    DirRight = 3'd4
  } dir_e;

  typedef struct packed {
    logic [7:0]                letter;
    logic [VelDigits-1:0][7:0] digit;
  } snap_t;

endpackage

// File: design/cfp_if.sv
// valid/ready channels of the command frame parser
// receive byte channel and decoded result channel, no dependencies
interface cfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfp_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] direction;
  logic [9:0] velocity;
  logic       bad_digit;
  modport source (output valid, output direction, output velocity, output bad_digit,
                  input ready);
  modport sink (input valid, input direction, input velocity, input bad_digit,
                output ready);
endinterface

// File: design/cfp_front.sv
// front end: classifies received bytes, fills the frame store and pushes
// a snapshot of the command slots when a frame closes; uses cfp_pkg, cfp_if
module cfp_front #(
  parameter int FRAME_SLOTS    = cfp_pkg::FrameSlots,
  parameter int DIRECTION_SLOT = cfp_pkg::DirectionSlot,
  parameter int VELOCITY_SLOT  = cfp_pkg::VelocitySlot
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     start_marker_i,
  input  logic [7:0]     stop_marker_i,
  cfp_rx_if.sink         rx,
  output logic           push_valid_o,
  input  logic           push_ready_i,
  output cfp_pkg::snap_t push_data_o
);

  localparam int IdxW = $clog2(FRAME_SLOTS);

  logic [FRAME_SLOTS-1:0][7:0] store_q;
  logic [IdxW-1:0]             idx_q, idx_d, idx_adv;
  logic                        in_frame_q, in_frame_d;
  logic                        accept, is_start, is_stop, we;

  assign rx.ready = push_ready_i;
  assign accept   = rx.valid && rx.ready;
  assign is_start = (rx.rx_byte == start_marker_i);
  assign is_stop  = in_frame_q && !is_start && (rx.rx_byte == stop_marker_i);
  assign idx_adv  = (idx_q < IdxW'(FRAME_SLOTS - 1)) ? idx_q + IdxW'(1) : idx_q;

  always_comb begin
    idx_d      = idx_q;
    in_frame_d = in_frame_q;
    we         = 1'b0;
    if (accept) begin
      if (is_start) begin
        idx_d      = '0;
        in_frame_d = 1'b1;
        we         = 1'b1;
      end else if (in_frame_q) begin
        idx_d = idx_adv;
        we    = 1'b1;
        if (is_stop) begin
          in_frame_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      in_frame_q <= 1'b0;
      store_q    <= '0;
    end else begin
      idx_q      <= idx_d;
      in_frame_q <= in_frame_d;
      if (we) begin
        store_q[idx_d] <= rx.rx_byte;
      end
    end
  end

  // slots beyond the store read as zero
  always_comb begin
    push_data_o = '0;
    if (DIRECTION_SLOT < FRAME_SLOTS) begin
      push_data_o.letter = store_q[IdxW'(DIRECTION_SLOT)];
    end
    for (int k = 0; k < cfp_pkg::VelDigits; k++) begin
      if (VELOCITY_SLOT + k < FRAME_SLOTS) begin
        push_data_o.digit[k] = store_q[IdxW'(VELOCITY_SLOT + k)];
      end
    end
  end

  assign push_valid_o = accept && is_stop;

endmodule

// File: design/cfp_queue.sv
// short fifo of frame snapshots between front and back end
// depends on cfp_pkg for the entry type
module cfp_queue #(
  parameter int DEPTH = cfp_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  cfp_pkg::snap_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output cfp_pkg::snap_t pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cfp_pkg::snap_t  mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= ptr_inc(wr_q);
      end
      if (pop) begin
        rd_q <= ptr_inc(rd_q);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: design/cfp_back.sv
// back end: decodes direction and velocity from a frame snapshot into the
// registered result beat; depends on cfp_pkg and cfp_if
module cfp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  cfp_pkg::snap_t pop_data_i,
  cfp_res_if.source      res
);

  cfp_pkg::dir_e held_q, held_d;
  logic          valid_q;
  logic [2:0]    dir_q;
  logic [9:0]    vel_q, vel_d;
  logic          bad_q, bad_d;
  logic          pop;
  logic [cfp_pkg::VelDigits-1:0][3:0] num;

  assign pop_ready_o = !valid_q || res.ready;
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    held_d = held_q;
    case (pop_data_i.letter)
      cfp_pkg::AsciiH: held_d = cfp_pkg::DirStop;
      cfp_pkg::AsciiF: held_d = cfp_pkg::DirFwd;
      cfp_pkg::AsciiB: held_d = cfp_pkg::DirBack;
      cfp_pkg::AsciiL: held_d = cfp_pkg::DirLeft;
      cfp_pkg::AsciiR: held_d = cfp_pkg::DirRight;
      default:         held_d = held_q;
    endcase
  end

  // digit[0] is the most significant character
  always_comb begin
    bad_d = 1'b0;
    for (int k = 0; k < cfp_pkg::VelDigits; k++) begin
      num[k] = 4'(pop_data_i.digit[k] - cfp_pkg::AsciiZero);
      if (!(pop_data_i.digit[k] inside {[cfp_pkg::AsciiZero:cfp_pkg::AsciiNine]})) begin
        bad_d = 1'b1;
      end
    end
    vel_d = 10'(num[0]) * 10'd100 + 10'(num[1]) * 10'd10 + 10'(num[2]);
    if (bad_d) begin
      vel_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= cfp_pkg::DirStop;
      valid_q <= 1'b0;
    end else begin
      if (pop) begin
        held_q  <= held_d;
        valid_q <= 1'b1;
      end else if (res.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      dir_q <= held_d;
      vel_q <= vel_d;
      bad_q <= bad_d;
    end
  end

  assign res.valid     = valid_q;
  assign res.direction = dir_q;
  assign res.velocity  = vel_q;
  assign res.bad_digit = bad_q;

endmodule

// File: design/command_frame_parser_top.sv
// command frame parser top level: marker registers on the apb port, front
// end, snapshot queue and back end; depends on cfp_pkg, cfp_if and submodules
//
//   channel  dir  beat                               handshake
//   rx_i     in   rx_byte[7:0]                       valid/ready
//   res_o    out  direction[2:0] velocity[9:0] bad   valid/ready
//   apb      in   start/stop marker at 0x0 / 0x4     psel/penable, pready high
//
// one byte per cycle while the queue has room; a frame byte is stored in the cycle it is taken
// a closing stop byte pushes a snapshot into a 2-entry queue, from which the back end registers a result beat
// rx_i stalls every byte while the queue is full, which a long res_o stall causes
// reset clears the frame store, slot index and held direction and sets the markers to their reset values
module command_frame_parser_top #(
  parameter int FRAME_SLOTS    = cfp_pkg::FrameSlots,
  parameter int DIRECTION_SLOT = cfp_pkg::DirectionSlot,
  parameter int VELOCITY_SLOT  = cfp_pkg::VelocitySlot
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cfp_pkg::AddrW-1:0] paddr,
  input  logic [cfp_pkg::DataW-1:0] pwdata,
  output logic [cfp_pkg::DataW-1:0] prdata,
  output logic                      pready,
  cfp_rx_if.sink                    rx_i,
  cfp_res_if.source                 res_o
);

  logic [7:0]     start_q, stop_q;
  logic           reg_idx;
  logic           push_valid, push_ready, pop_valid, pop_ready;
  cfp_pkg::snap_t push_data, pop_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= cfp_pkg::StartReset;
      stop_q  <= cfp_pkg::StopReset;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        cfp_pkg::RegStart: start_q <= pwdata[7:0];
        cfp_pkg::RegStop:  stop_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cfp_pkg::RegStart: prdata = {24'd0, start_q};
      cfp_pkg::RegStop:  prdata = {24'd0, stop_q};
      default:           prdata = '0;
    endcase
  end

  cfp_front #(
    .FRAME_SLOTS    (FRAME_SLOTS),
    .DIRECTION_SLOT (DIRECTION_SLOT),
    .VELOCITY_SLOT  (VELOCITY_SLOT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_marker_i (start_q),
    .stop_marker_i  (stop_q),
    .rx             (rx_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_data_o    (push_data)
  );

  cfp_queue #(
    .DEPTH (cfp_pkg::QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  cfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .res         (res_o)
  );

endmodule

// File: test/command_frame_parser_top_test.sv
// testbench for command_frame_parser_top: byte frames with random gaps and stalls,
// marker registers rewritten between phases, results checked against a frame decoder
// depends on cfp_pkg, cfp_if and the design under design/
module command_frame_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 400;

  typedef struct packed {
    cfp_pkg::dir_e direction;
    logic [9:0]    velocity;
    logic          bad_digit;
  } cmd_t;

  class cmd_frame_board;
    logic [7:0]    start_mark;
    logic [7:0]    stop_mark;
    logic [7:0]    frame_bytes [cfp_pkg::FrameSlots];
    int            slot;
    bit            in_frame;
    cfp_pkg::dir_e held_dir;
    cmd_t          cmd_q[$];
    int            fails;

    function new();
      start_mark = cfp_pkg::StartReset;
      stop_mark  = cfp_pkg::StopReset;
      foreach (frame_bytes[i]) frame_bytes[i] = 8'd0;
      slot     = 0;
      in_frame = 1'b0;
      held_dir = cfp_pkg::DirStop;
      fails    = 0;
    endfunction

    function void set_marker(logic sel, logic [7:0] value);
      if (sel == cfp_pkg::RegStart) begin
        start_mark = value;
      end else begin
        stop_mark = value;
      end
    endfunction

    function logic [7:0] slot_byte(int pos);
      return (pos < cfp_pkg::FrameSlots) ? frame_bytes[pos] : 8'd0;
    endfunction

    function cmd_t decode_frame();
      cmd_t       r;
      logic [7:0] c;
      int         vel;
      bit         bad;
      case (slot_byte(cfp_pkg::DirectionSlot))
        cfp_pkg::AsciiH: held_dir = cfp_pkg::DirStop;
        cfp_pkg::AsciiF: held_dir = cfp_pkg::DirFwd;
        cfp_pkg::AsciiB: held_dir = cfp_pkg::DirBack;
        cfp_pkg::AsciiL: held_dir = cfp_pkg::DirLeft;
        cfp_pkg::AsciiR: held_dir = cfp_pkg::DirRight;
        default: ;
      endcase
      vel = 0;
      bad = 1'b0;
      for (int k = 0; k < cfp_pkg::VelDigits; k++) begin
        c = slot_byte(cfp_pkg::VelocitySlot + k);
        if (c < cfp_pkg::AsciiZero || c > cfp_pkg::AsciiNine) begin
          bad = 1'b1;
        end else begin
          vel = vel * 10 + int'(c - cfp_pkg::AsciiZero);
        end
      end
      r.direction = held_dir;
      r.velocity  = bad ? 10'd0 : 10'(vel);
      r.bad_digit = bad;
      return r;
    endfunction

    // one accepted byte on the receive channel
    function void take_byte(logic [7:0] b);
      if (b == start_mark) begin
        slot           = 0;
        in_frame       = 1'b1;
        frame_bytes[0] = b;
        return;
      end
      if (!in_frame) return;
      if (slot < cfp_pkg::FrameSlots - 1) slot++;
      if (b == stop_mark) begin
        in_frame = 1'b0;
        cmd_q.push_back(decode_frame());
      end
      frame_bytes[slot] = b;
    endfunction

    function void check_cmd(logic [2:0] dir, logic [9:0] vel, logic bad);
      cmd_t want;
      if (cmd_q.size() == 0) begin
        fails++;
        $display("%0t: unexpected result beat dir %0d vel %0d bad %0d", $time, dir, vel, bad);
        return;
      end
      want = cmd_q.pop_front();
      if (dir !== want.direction) begin
        fails++;
        $display("%0t: direction expected %0d actual %0d", $time, want.direction, dir);
      end
      if (vel !== want.velocity) begin
        fails++;
        $display("%0t: velocity expected %0d actual %0d", $time, want.velocity, vel);
      end
      if (bad !== want.bad_digit) begin
        fails++;
        $display("%0t: bad_digit expected %0d actual %0d", $time, want.bad_digit, bad);
      end
    endfunction

    function int pending();
      return cmd_q.size();
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [cfp_pkg::AddrW-1:0]   paddr;
  logic [cfp_pkg::DataW-1:0]   pwdata;
  logic [cfp_pkg::DataW-1:0]   prdata;
  logic                        pready;
  bit                          rx_quiet;
  bit                          res_quiet;
  int                          idle_cycles;
  cmd_frame_board              board = new();

  cfp_rx_if  rx ();
  cfp_res_if res ();

  command_frame_parser_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rx_i    (rx),
    .res_o   (res)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rx.valid && rx.ready) board.take_byte(rx.rx_byte);
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res.valid && res.ready) begin
      board.check_cmd(res.direction, res.velocity, res.bad_digit);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (rx.valid && rx.ready) || (res.valid && res.ready) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stall before each beat, with calm stretches
  initial begin
    int stall;
    res_quiet = 1'b0;
    res.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) res_quiet = !res_quiet;
      stall = res_quiet ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (!res.valid);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = rx_quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk_i); while (!rx.ready);
  endtask

  task automatic drain_results();
    rx.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  task automatic apb_write(input logic sel, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {24'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_marker(sel, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_markers(input logic [7:0] start_v, input logic [7:0] stop_v);
    drain_results();
    repeat (4) @(posedge clk_i);
    apb_write(cfp_pkg::RegStart, start_v);
    apb_write(cfp_pkg::RegStop, stop_v);
  endtask

  // start, letter, three digits, stop; sometimes short, long or left open
  task automatic send_frame(output int n_bytes);
    logic [7:0] body[$];
    logic [7:0] letter_set[5];
    int         shape;
    letter_set = '{cfp_pkg::AsciiH, cfp_pkg::AsciiF, cfp_pkg::AsciiB, cfp_pkg::AsciiL,
                   cfp_pkg::AsciiR};
    shape = $urandom_range(0, 9);
    body.push_back(($urandom_range(0, 9) != 0) ? letter_set[$urandom_range(0, 4)]
                                                : 8'($urandom()));
    for (int k = 0; k < cfp_pkg::VelDigits; k++) begin
      body.push_back(($urandom_range(0, 11) != 0)
                     ? cfp_pkg::AsciiZero + 8'($urandom_range(0, 9))
                     : 8'($urandom()));
    end
    if (shape == 0) begin
      repeat ($urandom_range(1, 4)) void'(body.pop_back());
    end else if (shape == 1) begin
      repeat ($urandom_range(1, 6)) body.push_back(8'($urandom()));
    end
    send_byte(board.start_mark);
    foreach (body[i]) send_byte(body[i]);
    if (shape != 2) send_byte(board.stop_mark);
    n_bytes = body.size() + ((shape != 2) ? 2 : 1);
  endtask

  task automatic random_traffic(input int count);
    int sent;
    int n;
    int next_pause;
    sent       = 0;
    next_pause = 150;
    while (sent < count) begin
      rx_quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) send_byte(8'($urandom()));
        sent += n;
      end else begin
        send_frame(n);
        sent += n;
      end
      if (sent >= next_pause) begin
        drain_results();
        next_pause += 150;
      end
    end
  endtask

  initial begin
    logic [7:0] directed_q[$];
    rst_ni     <= 1'b0;
    rx.valid   <= 1'b0;
    rx.rx_byte <= 8'd0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    rx_quiet   = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_q = {8'hFF, cfp_pkg::StopReset,
                  cfp_pkg::StartReset, cfp_pkg::StopReset,
                  cfp_pkg::StartReset, cfp_pkg::AsciiF, cfp_pkg::AsciiNine,
                  cfp_pkg::AsciiNine, cfp_pkg::AsciiNine, cfp_pkg::StopReset,
                  cfp_pkg::StartReset, cfp_pkg::AsciiL, cfp_pkg::StopReset,
                  cfp_pkg::StartReset, cfp_pkg::AsciiR, cfp_pkg::AsciiNine + 8'd1,
                  cfp_pkg::AsciiZero - 8'd1, cfp_pkg::AsciiZero,
                  cfp_pkg::StopReset,
                  cfp_pkg::StartReset, cfp_pkg::AsciiH, cfp_pkg::AsciiZero,
                  cfp_pkg::AsciiZero, cfp_pkg::AsciiZero,
                  8'h00, 8'hFF, 8'h5A, 8'hA5, cfp_pkg::StopReset};
    foreach (directed_q[i]) send_byte(directed_q[i]);

    random_traffic(170);
    set_markers(8'h00, 8'hFF);
    random_traffic(170);
    set_markers(8'hFF, 8'h00);
    random_traffic(170);
    set_markers(8'h41, 8'h41);
    random_traffic(60);
    set_markers(8'($urandom()), 8'($urandom()));
    random_traffic(170);
    set_markers(cfp_pkg::StartReset, cfp_pkg::StopReset);
    random_traffic(170);
    set_markers(8'($urandom()), 8'($urandom()));
    random_traffic(170);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (board.fails == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/cfp_pkg.sv
design/cfp_if.sv
design/cfp_front.sv
design/cfp_queue.sv
design/cfp_back.sv
design/command_frame_parser_top.sv
test/command_frame_parser_top_test.sv
